// ===== hw/rtl/dhcp_option_parser_macros.svh =====
// Assertion macros for the DHCP option parser checker.
// Every macro expects aclk to be visible where it is used; the first two also need aresetn.
`ifndef DHCP_OPTION_PARSER_MACROS_SVH
`define DHCP_OPTION_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DOP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DOP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define DOP_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dop_pkg.sv =====
// Shared types and constants of the DHCP option parser.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package dop_pkg;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    // Register index of the default mask register, taken from paddr[2].
    localparam logic REG_DEFAULT_MASK = 1'b0;

    localparam logic [31:0] DEFAULT_MASK_RESET = 32'hFFFF_FF00;

    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_SUBNET   = 8'd1;
    localparam logic [7:0] OPT_ROUTER   = 8'd3;
    localparam logic [7:0] OPT_DNS      = 8'd6;
    localparam logic [7:0] OPT_LEASE    = 8'd51;
    localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0] OPT_SERVER   = 8'd54;
    localparam logic [7:0] OPT_END      = 8'd255;

    localparam logic [2:0] FULL_VALUE = 3'd4;

    typedef struct packed {
        logic [7:0]  msg_type;
        logic [31:0] net_mask;
        logic [31:0] router_addr;
        logic [31:0] dns_addr;
        logic [31:0] lease_seconds;
        logic [31:0] server_id;
        logic        end_seen;
    } result_t;

endpackage

// ===== hw/rtl/dhcp_option_parser.sv =====
// DHCP option parser: one options-area byte per transfer, result on the last byte.
// Results are registered in the output or skid register as their last byte is taken.
// Throughput: one byte per cycle while s_ready is high; walk state updates once per byte.
// An output register plus one skid register let input continue while a result waits.
// Reset (aresetn low, synchronous) clears the walk and stores; both masks load 0xFFFFFF00.
// Depends on dop_pkg.
`timescale 1ns / 1ps

module dhcp_option_parser #(
    parameter int unsigned OPTION_AREA_BYTES = 312
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dop_pkg::PADDR_W-1:0]  paddr,
    input  logic [dop_pkg::PDATA_W-1:0]  pwdata,
    output logic [dop_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_opt_byte,
    input  logic                         s_first_byte,
    input  logic                         s_last_byte,
    input  logic                         s_clear_offer,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_msg_type,
    output logic [31:0]                  m_net_mask,
    output logic [31:0]                  m_router_addr,
    output logic [31:0]                  m_dns_addr,
    output logic [31:0]                  m_lease_seconds,
    output logic [31:0]                  m_server_id,
    output logic                         m_end_seen
);
    import dop_pkg::*;

    localparam int unsigned AREA_W = $clog2(OPTION_AREA_BYTES + 1);
    localparam logic [AREA_W-1:0] AREA_LIMIT = AREA_W'(OPTION_AREA_BYTES);

    typedef enum logic [1:0] {
        PH_CODE,
        PH_LEN,
        PH_VALUE
    } phase_t;

    logic [31:0]       mask_cfg_reg;

    phase_t            phase_reg, phase_next;
    logic [7:0]        code_reg, code_next;
    logic [7:0]        left_reg, left_next;
    logic [2:0]        count_reg, count_next;
    logic [31:0]       shift_reg, shift_next;
    logic [AREA_W-1:0] area_reg, area_next;
    logic              stopped_reg, stopped_next;
    logic [7:0]        type_reg, type_next;
    logic [31:0]       mask_reg, mask_next;
    logic [31:0]       router_reg, router_next;
    logic [31:0]       dns_reg, dns_next;
    logic [31:0]       lease_reg, lease_next;
    logic [31:0]       server_reg, server_next;

    result_t           out_reg, skid_reg, result_next;
    logic              out_valid_reg, skid_valid_reg;

    logic              accept;
    logic              cfg_write;
    logic [31:0]       value_shift;
    logic [2:0]        value_count;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_DEFAULT_MASK) ? mask_cfg_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_cfg_reg <= DEFAULT_MASK_RESET;
        end else if (cfg_write && paddr[2] == REG_DEFAULT_MASK) begin
            mask_cfg_reg <= pwdata;
        end
    end

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;

    // Walk state after the per-message resets, then one byte of parsing.
    always_comb begin
        value_shift  = '0;
        value_count  = '0;
        phase_next   = phase_reg;
        code_next    = code_reg;
        left_next    = left_reg;
        count_next   = count_reg;
        shift_next   = shift_reg;
        area_next    = area_reg;
        stopped_next = stopped_reg;
        type_next    = type_reg;
        mask_next    = mask_reg;
        router_next  = router_reg;
        dns_next     = dns_reg;
        lease_next   = lease_reg;
        server_next  = server_reg;

        if (s_first_byte) begin
            phase_next   = PH_CODE;
            code_next    = '0;
            left_next    = '0;
            count_next   = '0;
            shift_next   = '0;
            area_next    = '0;
            stopped_next = 1'b0;
            type_next    = '0;
            if (s_clear_offer) begin
                mask_next   = mask_cfg_reg;
                router_next = '0;
                dns_next    = '0;
                lease_next  = '0;
                server_next = '0;
            end
        end

        if (!stopped_next && area_next < AREA_LIMIT) begin
            area_next = area_next + 1'b1;
            case (phase_next)
                PH_LEN: begin
                    left_next  = s_opt_byte;
                    count_next = '0;
                    shift_next = '0;
                    phase_next = (s_opt_byte == 8'd0) ? PH_CODE : PH_VALUE;
                end
                PH_VALUE: begin
                    value_shift = shift_next;
                    value_count = count_next;
                    if (count_next < FULL_VALUE) begin
                        value_shift = {shift_next[23:0], s_opt_byte};
                        value_count = count_next + 1'b1;
                    end
                    shift_next = value_shift;
                    count_next = value_count;
                    left_next  = left_next - 1'b1;
                    if (left_next == 8'd0) begin
                        phase_next = PH_CODE;
                        if (code_next == OPT_MSG_TYPE) begin
                            // The first value byte sits count-1 bytes above the bottom.
                            case (value_count)
                                3'd1:    type_next = value_shift[7:0];
                                3'd2:    type_next = value_shift[15:8];
                                3'd3:    type_next = value_shift[23:16];
                                3'd4:    type_next = value_shift[31:24];
                                default: type_next = type_next;
                            endcase
                        end else if (value_count == FULL_VALUE) begin
                            case (code_next)
                                OPT_SUBNET: mask_next   = value_shift;
                                OPT_ROUTER: router_next = value_shift;
                                OPT_DNS:    dns_next    = value_shift;
                                OPT_LEASE:  lease_next  = value_shift;
                                OPT_SERVER: server_next = value_shift;
                                default:    mask_next   = mask_next;
                            endcase
                        end
                    end
                end
                default: begin
                    phase_next = PH_CODE;
                    if (s_opt_byte == OPT_END) begin
                        stopped_next = 1'b1;
                    end else if (s_opt_byte != OPT_PAD) begin
                        code_next  = s_opt_byte;
                        phase_next = PH_LEN;
                    end
                end
            endcase
        end

        result_next.msg_type      = type_next;
        result_next.net_mask      = mask_next;
        result_next.router_addr   = router_next;
        result_next.dns_addr      = dns_next;
        result_next.lease_seconds = lease_next;
        result_next.server_id     = server_next;
        result_next.end_seen      = stopped_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_CODE;
            code_reg    <= '0;
            left_reg    <= '0;
            count_reg   <= '0;
            shift_reg   <= '0;
            area_reg    <= '0;
            stopped_reg <= 1'b0;
            type_reg    <= '0;
            mask_reg    <= DEFAULT_MASK_RESET;
            router_reg  <= '0;
            dns_reg     <= '0;
            lease_reg   <= '0;
            server_reg  <= '0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            code_reg    <= code_next;
            left_reg    <= left_next;
            count_reg   <= count_next;
            shift_reg   <= shift_next;
            area_reg    <= area_next;
            stopped_reg <= stopped_next;
            type_reg    <= type_next;
            mask_reg    <= mask_next;
            router_reg  <= router_next;
            dns_reg     <= dns_next;
            lease_reg   <= lease_next;
            server_reg  <= server_next;
        end
    end

    // A new result goes to the skid register only when the output register
    // is held; s_ready is low while the skid register is full.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !m_ready) begin
            if (accept && s_last_byte) begin
                skid_reg       <= result_next;
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_reg        <= skid_reg;
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            out_reg       <= result_next;
            out_valid_reg <= accept && s_last_byte;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_msg_type      = out_reg.msg_type;
    assign m_net_mask      = out_reg.net_mask;
    assign m_router_addr   = out_reg.router_addr;
    assign m_dns_addr      = out_reg.dns_addr;
    assign m_lease_seconds = out_reg.lease_seconds;
    assign m_server_id     = out_reg.server_id;
    assign m_end_seen      = out_reg.end_seen;

endmodule

// ===== hw/rtl/dop_checker.sv =====
// Port-level checker for the DHCP option parser, bound to its top level.
// Depends on dop_pkg and dhcp_option_parser_macros.svh.
`timescale 1ns / 1ps
`include "dhcp_option_parser_macros.svh"

module dop_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [dop_pkg::PADDR_W-1:0] paddr,
    input logic                        pready,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        s_last_byte,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [31:0]                 m_net_mask
);
    import dop_pkg::*;

    logic cfg_mask_write;

    assign cfg_mask_write = psel && penable && pwrite && pready &&
                            (paddr[2] == REG_DEFAULT_MASK);

    // The skid register only fills behind a full output register.
    `DOP_ASSERT_NOW(a_skid_behind_out, !s_ready, m_valid, "input stalled with output empty")

    // A result arriving while the output is held must fill the skid register.
    `DOP_ASSERT_NEXT(a_skid_fills, m_valid && !m_ready && s_valid && s_ready && s_last_byte,
        !s_ready, "held result and new result but input still ready")

    // Nothing is shown on the result channel right after reset.
    `DOP_ASSERT_ALWAYS(a_reset_empty, !aresetn, !m_valid && s_ready,
        "result channel not empty after reset")

    // A held result keeps its net mask while the mask register is rewritten.
    `DOP_ASSERT_NEXT(a_hold_stable, m_valid && !m_ready && cfg_mask_write,
        m_valid && $stable(m_net_mask), "held result changed by configuration write")

endmodule

bind dhcp_option_parser dop_checker u_dop_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pready        (pready),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_last_byte   (s_last_byte),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_net_mask    (m_net_mask)
);
